[rtl/core/bhpq_pkg.sv]
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and codes for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int CAP_W    = 9;
  localparam int OCC_W    = 9;
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_KEY_ORDER = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             key_order;
  } cfg_t;

endpackage

[rtl/core/bhpq_if.sv]
// ----------------------------------------------------------------------------
// bhpq_if
// Request and result channels (valid/ready) of the heap queue.
// ----------------------------------------------------------------------------
interface bhpq_req_if #(
  parameter int INDEX_WIDTH = 8,
  parameter int KEY_WIDTH   = 32
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [INDEX_WIDTH-1:0]        entry_index;
  logic signed [KEY_WIDTH-1:0]   entry_key;

  modport source (output valid, mode, entry_index, entry_key, input ready);
  modport sink   (input valid, mode, entry_index, entry_key, output ready);
endinterface

interface bhpq_rsp_if #(
  parameter int INDEX_WIDTH = 8
);
  logic                          valid;
  logic                          ready;
  logic [INDEX_WIDTH-1:0]        popped_index;
  logic [bhpq_pkg::STATUS_W-1:0] status;
  logic [bhpq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, popped_index, status, occupancy, input ready);
  modport sink   (input valid, popped_index, status, occupancy, output ready);
endinterface

[rtl/core/bhpq_ram.sv]
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bhpq_cfg.sv]
// ----------------------------------------------------------------------------
// bhpq_cfg
// APB register file: capacity and key order.
// ----------------------------------------------------------------------------
module bhpq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhpq_pkg::APB_AW-1:0]   paddr,
  input  logic [bhpq_pkg::APB_DW-1:0]   pwdata,
  output logic [bhpq_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output bhpq_pkg::cfg_t                cfg
);

  logic wr;
  logic sel;

  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity  <= bhpq_pkg::CAP_W'(256);
      cfg.key_order <= 1'b0;
    end else if (wr) begin
      case (sel)
        bhpq_pkg::REG_CAPACITY:  cfg.capacity  <= pwdata[bhpq_pkg::CAP_W-1:0];
        bhpq_pkg::REG_KEY_ORDER: cfg.key_order <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (sel)
      bhpq_pkg::REG_CAPACITY:  prdata[bhpq_pkg::CAP_W-1:0] = cfg.capacity;
      bhpq_pkg::REG_KEY_ORDER: prdata[0] = cfg.key_order;
      default: prdata = '0;
    endcase
  end

endmodule

[rtl/core/binary_heap_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// Binary heap of (index, key) entries in one RAM; push sifts up, pop sifts down.
// ----------------------------------------------------------------------------
// Push: writes the new entry at the end and sifts it up, reading and comparing one parent per level.
// Pop: reads the root, moves the last entry to the root and sifts it down.
// Refused push or empty pop: the result word is set from the idle state, with no heap walk.
// Each level costs one RAM read and one compare on push, and up to two of each on pop (registered read).
// Reset clears the count and restores capacity 256, smallest first; RAM is not cleared.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit #(
  parameter int DEPTH       = 256,
  parameter int INDEX_WIDTH = 8,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  bhpq_req_if.sink                    in_ch,
  bhpq_rsp_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bhpq_pkg::APB_AW-1:0] paddr,
  input  logic [bhpq_pkg::APB_DW-1:0] pwdata,
  output logic [bhpq_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = AW + 2;
  localparam int EW    = INDEX_WIDTH + KEY_WIDTH;
  localparam int LW    = (CNT_W > bhpq_pkg::CAP_W) ? CNT_W : bhpq_pkg::CAP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_UP, S_UP_CMP, S_POP_ROOT, S_POP_LAST, S_DN, S_DN_L, S_DN_R
  } state_t;

  function automatic logic prec(input logic [KEY_WIDTH-1:0] a,
                                input logic [KEY_WIDTH-1:0] b,
                                input logic                 o);
    return o ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

  bhpq_pkg::cfg_t cfg;

  state_t                     state;
  logic [CNT_W-1:0]           cnt;
  logic [AW-1:0]              pos;
  logic [EW-1:0]              mov;
  logic [EW-1:0]              lft;
  logic                       res_valid;
  logic [INDEX_WIDTH-1:0]     res_idx;
  bhpq_pkg::status_t          res_status;
  logic [bhpq_pkg::OCC_W-1:0] res_occ;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [EW-1:0]              wdata;
  logic [AW-1:0]              raddr;
  logic [EW-1:0]              rdata;

  logic [LW-1:0]              limit;
  logic [LW-1:0]              cnt_l;
  logic [bhpq_pkg::OCC_W-1:0] occ;
  logic [PW-1:0]              left_w;
  logic [PW-1:0]              right_w;
  logic [PW-1:0]              cnt_w;
  logic                       has_left;
  logic                       has_right;
  logic [AW-1:0]              parent;
  logic [KEY_WIDTH-1:0]       mov_key;
  logic [KEY_WIDTH-1:0]       rd_key;
  logic [KEY_WIDTH-1:0]       lft_key;
  logic                       up_swap;
  logic                       swap_l;
  logic                       l_first;
  logic [EW-1:0]              c_ent;
  logic [AW-1:0]              c_addr;
  logic                       dn_stop;
  logic                       accept;

  bhpq_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bhpq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign cnt_l   = LW'(cnt);
  assign limit   = (LW'(cfg.capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cfg.capacity);
  assign occ     = cnt_l[bhpq_pkg::OCC_W-1:0];
  assign left_w  = PW'({pos, 1'b1});
  assign right_w = left_w + PW'(1);
  assign cnt_w   = PW'(cnt);
  assign has_left  = left_w < cnt_w;
  assign has_right = right_w < cnt_w;
  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign mov_key = mov[KEY_WIDTH-1:0];
  assign rd_key  = rdata[KEY_WIDTH-1:0];
  assign lft_key = lft[KEY_WIDTH-1:0];
  assign up_swap = prec(mov_key, rd_key, cfg.key_order);
  assign swap_l  = prec(rd_key, mov_key, cfg.key_order);
  assign l_first = prec(lft_key, rd_key, cfg.key_order);
  assign c_ent   = l_first ? lft : rdata;
  assign c_addr  = l_first ? left_w[AW-1:0] : right_w[AW-1:0];
  assign dn_stop = prec(mov_key, c_ent[KEY_WIDTH-1:0], cfg.key_order);

  assign in_ch.ready         = (state == S_IDLE) && (!res_valid || out_ch.ready);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = res_valid;
  assign out_ch.popped_index = res_idx;
  assign out_ch.status       = res_status;
  assign out_ch.occupancy    = res_occ;

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = mov;
    raddr = '0;
    case (state)
      S_POP_ROOT: raddr = AW'(cnt);
      S_UP: begin
        if (pos == '0) we = 1'b1;
        else raddr = parent;
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_swap) wdata = rdata;
      end
      S_DN: begin
        if (!has_left) we = 1'b1;
        else raddr = left_w[AW-1:0];
      end
      S_DN_L: begin
        if (has_right) begin
          raddr = right_w[AW-1:0];
        end else begin
          we = 1'b1;
          if (swap_l) wdata = rdata;
        end
      end
      S_DN_R: begin
        we = 1'b1;
        if (!dn_stop) wdata = c_ent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && out_ch.ready && !accept) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_idx    <= '0;
            res_status <= bhpq_pkg::ST_DONE;
            if (in_ch.mode == bhpq_pkg::MODE_PUSH) begin
              if (cnt_l >= limit) begin
                res_status <= bhpq_pkg::ST_FULL;
                res_occ    <= occ;
                res_valid  <= 1'b1;
              end else begin
                mov       <= {in_ch.entry_index, in_ch.entry_key};
                pos       <= AW'(cnt);
                cnt       <= cnt + CNT_W'(1);
                res_valid <= 1'b0;
                state     <= S_UP;
              end
            end else begin
              if (cnt == '0) begin
                res_status <= bhpq_pkg::ST_EMPTY;
                res_occ    <= occ;
                res_valid  <= 1'b1;
              end else begin
                cnt       <= cnt - CNT_W'(1);
                res_valid <= 1'b0;
                state     <= S_POP_ROOT;
              end
            end
          end
        end
        S_UP: begin
          if (pos == '0) begin
            res_occ   <= occ;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_swap) begin
            pos   <= parent;
            state <= S_UP;
          end else begin
            res_occ   <= occ;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_POP_ROOT: begin
          res_idx <= rdata[EW-1:KEY_WIDTH];
          state   <= S_POP_LAST;
        end
        S_POP_LAST: begin
          mov <= rdata;
          pos <= '0;
          if (cnt == '0) begin
            res_occ   <= occ;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_DN;
          end
        end
        S_DN: begin
          if (!has_left) begin
            res_occ   <= occ;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_DN_L;
          end
        end
        S_DN_L: begin
          lft <= rdata;
          if (has_right) begin
            state <= S_DN_R;
          end else if (swap_l) begin
            pos   <= left_w[AW-1:0];
            state <= S_DN;
          end else begin
            res_occ   <= occ;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DN_R: begin
          if (dn_stop) begin
            res_occ   <= occ;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            pos   <= c_addr;
            state <= S_DN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(cnt) <= LW'(DEPTH))
    else $error("entry count above depth");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == bhpq_pkg::ST_EMPTY |-> res_occ == '0)
    else $error("empty status with nonzero occupancy");

  a_full_idx: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == bhpq_pkg::ST_FULL |-> res_idx == '0)
    else $error("refused push reports an index");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready)
    else $error("word taken while heap operation in flight");

endmodule

[tb/tb_binary_heap_priority_queue_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue_unit
// Drives push and pop words into the heap queue and checks every result word
// against a behavioral heap kept in the bench, across capacity and order
// settings, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue_unit;

  localparam int DEPTH = 256;

  typedef struct {
    logic [7:0]          idx;
    bhpq_pkg::status_t   st;
    logic [8:0]          occ;
  } heap_rsp_t;

  typedef struct {
    logic [7:0]  idx;
    logic signed [31:0] key;
  } heap_slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bhpq_pkg::APB_AW-1:0] paddr = '0;
  logic [bhpq_pkg::APB_DW-1:0] pwdata = '0;
  logic [bhpq_pkg::APB_DW-1:0] prdata;
  logic pready;

  bhpq_req_if #(.INDEX_WIDTH(8), .KEY_WIDTH(32)) in_ch ();
  bhpq_rsp_if #(.INDEX_WIDTH(8)) out_ch ();

  binary_heap_priority_queue_unit #(.DEPTH(DEPTH), .INDEX_WIDTH(8), .KEY_WIDTH(32)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  heap_slot_t heap_mem[DEPTH];
  int unsigned heap_cnt;
  int unsigned cap_reg;
  bit max_first;
  heap_rsp_t expected_q[$];
  int mismatches;
  bit gaps_on;
  int stall_hold;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = bhpq_pkg::MODE_PUSH;
    in_ch.entry_index = '0;
    in_ch.entry_key = '0;
    out_ch.ready = 1'b0;
  end

  function automatic bit precedes(heap_slot_t a, heap_slot_t b);
    return max_first ? (a.key > b.key) : (a.key < b.key);
  endfunction

  function automatic heap_rsp_t heap_apply(logic mode, logic [7:0] idx, logic signed [31:0] key);
    heap_rsp_t r;
    heap_slot_t t;
    int unsigned k, p, i, l, rt, c, lim;
    r.idx = '0;
    r.st = bhpq_pkg::ST_DONE;
    lim = cap_reg < DEPTH ? cap_reg : DEPTH;
    if (mode == bhpq_pkg::MODE_PUSH) begin
      if (heap_cnt >= lim) begin
        r.st = bhpq_pkg::ST_FULL;
      end else begin
        k = heap_cnt;
        heap_mem[k].idx = idx;
        heap_mem[k].key = key;
        while (k > 0) begin
          p = (k - 1) / 2;
          if (!precedes(heap_mem[k], heap_mem[p])) break;
          t = heap_mem[k]; heap_mem[k] = heap_mem[p]; heap_mem[p] = t;
          k = p;
        end
        heap_cnt++;
      end
    end else if (heap_cnt == 0) begin
      r.st = bhpq_pkg::ST_EMPTY;
    end else begin
      heap_cnt--;
      t = heap_mem[0]; heap_mem[0] = heap_mem[heap_cnt]; heap_mem[heap_cnt] = t;
      i = 0;
      forever begin
        l = 2 * i + 1;
        rt = 2 * i + 2;
        if (l >= heap_cnt) break;
        if (rt >= heap_cnt) rt = i;
        c = precedes(heap_mem[l], heap_mem[rt]) ? l : rt;
        if (precedes(heap_mem[i], heap_mem[c])) c = i;
        if (c == i) break;
        t = heap_mem[i]; heap_mem[i] = heap_mem[c]; heap_mem[c] = t;
        i = c;
      end
      r.idx = heap_mem[heap_cnt].idx;
    end
    r.occ = heap_cnt[8:0];
    return r;
  endfunction

  task automatic send_word(logic mode, logic [7:0] idx, logic signed [31:0] key);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.entry_index <= idx;
    in_ch.entry_key <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(heap_apply(mode, idx, key));
  endtask

  task automatic send_random(int n, int push_pct);
    int j;
    logic [31:0] k;
    for (j = 0; j < n; j++) begin
      case ($urandom_range(0, 3))
        0: k = $urandom_range(0, 7);
        1: k = $urandom_range(0, 1) ? (32'h8000_0000 | $urandom_range(0, 15))
                                    : (32'h7fff_fff0 | $urandom_range(0, 15));
        default: k = $urandom;
      endcase
      send_word($urandom_range(0, 99) < push_pct ? bhpq_pkg::MODE_PUSH : bhpq_pkg::MODE_POP,
                8'($urandom_range(0, 255)), k);
    end
  endtask

  task automatic drain_queue();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= bhpq_pkg::APB_AW'(4 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == bhpq_pkg::REG_CAPACITY) cap_reg = val & 9'h1ff;
    else max_first = val[0];
    @(posedge clk);
  endtask

  task automatic test_directed();
    int j;
    send_word(bhpq_pkg::MODE_POP, 8'hff, 32'h7fffffff);
    send_word(bhpq_pkg::MODE_PUSH, 8'hff, 32'h7fffffff);
    send_word(bhpq_pkg::MODE_PUSH, 8'h00, 32'h80000000);
    send_word(bhpq_pkg::MODE_PUSH, 8'h55, 32'h0);
    send_word(bhpq_pkg::MODE_PUSH, 8'haa, 32'h0);
    send_word(bhpq_pkg::MODE_PUSH, 8'h01, 32'hffffffff);
    send_word(bhpq_pkg::MODE_PUSH, 8'h02, 32'h0);
    for (j = 0; j < 7; j++) send_word(bhpq_pkg::MODE_POP, 8'h00, 32'h0);
    drain_queue();
  endtask

  task automatic test_max_order();
    write_reg(bhpq_pkg::REG_KEY_ORDER, 1);
    send_word(bhpq_pkg::MODE_PUSH, 8'h10, 32'h80000000);
    send_word(bhpq_pkg::MODE_PUSH, 8'h11, 32'h7fffffff);
    send_word(bhpq_pkg::MODE_PUSH, 8'h12, 32'h7fffffff);
    send_random(300, 60);
    drain_queue();
    write_reg(bhpq_pkg::REG_KEY_ORDER, 0);
  endtask

  task automatic test_capacity();
    write_reg(bhpq_pkg::REG_CAPACITY, 0);
    send_random(20, 60);
    drain_queue();
    write_reg(bhpq_pkg::REG_CAPACITY, 3);
    send_random(150, 65);
    drain_queue();
    write_reg(bhpq_pkg::REG_CAPACITY, 511);
    send_random(200, 55);
    drain_queue();
  endtask

  task automatic test_fill_full();
    write_reg(bhpq_pkg::REG_CAPACITY, 256);
    send_random(280, 100);
    send_random(280, 0);
    drain_queue();
  endtask

  task automatic test_backpressure();
    stall_hold = 200;
    send_random(60, 70);
    drain_queue();
  endtask

  task automatic test_random_mix();
    send_random(560, 55);
    gaps_on = 1'b0;
    send_random(100, 50);
    drain_queue();
  endtask

  always @(posedge clk) begin
    heap_rsp_t e;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word occ=%0d", out_ch.occupancy);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.popped_index !== e.idx || out_ch.status !== e.st ||
            out_ch.occupancy !== e.occ) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d st=%0d occ=%0d got idx=%0d st=%0d occ=%0d",
                     e.idx, e.st, e.occ, out_ch.popped_index, out_ch.status,
                     out_ch.occupancy);
        end
      end
    end
  end

  initial begin
    int burst;
    @(negedge rst);
    forever begin
      if (stall_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall_hold) @(posedge clk);
        stall_hold = 0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        burst = $urandom_range(1, 20);
        repeat (burst) @(posedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    heap_cnt = 0;
    cap_reg = 256;
    max_first = 1'b0;
    mismatches = 0;
    gaps_on = 1'b1;
    stall_hold = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_max_order();
    test_capacity();
    test_fill_full();
    test_backpressure();
    test_random_mix();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
